>>> design/fhlb_pkg.sv
`timescale 1ns / 1ps

package fhlb_pkg;

    localparam int TABLE_DEPTH = 16384;
    localparam int GATE_LIMIT  = 8192;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int INDEX_W = 14;
    localparam int GATE_W  = 13;
    localparam int COUNT_W = 15;
    localparam int HASH_W  = 32;
    localparam int VEC_W   = 96;

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

    localparam logic FUNC_CLASSIFY = 1'b0;
    localparam logic FUNC_WRITE    = 1'b1;

    localparam logic [1:0] MODE_MAC = 2'd0;
    localparam logic [1:0] MODE_IP  = 2'd1;
    localparam logic [1:0] MODE_L4  = 2'd2;
    localparam logic [1:0] MODE_BAD = 2'd3;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_LB_MODE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_COUNT = 8'd1;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic        func;
        logic [63:0] mac_word;
        logic [31:0] mac_tail;
        logic [63:0] ip_pair;
        logic [31:0] port_word;
        logic [7:0]  proto_byte;
        logic [INDEX_W-1:0] entry_index;
        logic [GATE_W-1:0]  entry_gate;
        logic        entry_drop;
    } in_item_t;

    typedef struct packed {
        logic [GATE_W-1:0] out_gate;
        logic              out_drop;
        logic [HASH_W-1:0] flow_hash;
    } out_item_t;

    // Hash pipeline result handed to the table stage
    typedef struct packed {
        logic               valid;
        logic               func;
        logic [HASH_W-1:0]  hash;
        logic [IDX_W-1:0]   bucket;
        logic               zero;
        logic [INDEX_W-1:0] entry_index;
        logic [GATE_W-1:0]  entry_gate;
        logic               entry_drop;
    } hash_stage_t;

    // CRC contribution of each input bit: data bits 0..63, then seed bits 0..31.
    // The update is linear, so the hash is the XOR of the columns of set bits.
    function automatic logic [VEC_W-1:0][31:0] crc_cols();
        logic [VEC_W-1:0][31:0] cols;
        logic [31:0] crc;
        logic [63:0] data;
        for (int k = 0; k < VEC_W; k++)
        begin
            if (k < 64)
            begin
                data = 64'd1 << k;
                crc  = 32'd0;
            end
            else
            begin
                data = 64'd0;
                crc  = 32'd1 << (k - 64);
            end
            for (int i = 0; i < 8; i++)
            begin
                crc = crc ^ {24'd0, data[8*i +: 8]};
                for (int b = 0; b < 8; b++)
                begin
                    crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
                end
            end
            cols[k] = crc;
        end
        return cols;
    endfunction

    localparam logic [VEC_W-1:0][31:0] CRC_COLS = crc_cols();

endpackage

>>> design/flow_hash_load_balancer_top.sv
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// in        in_valid / in_stall         in_data   (in_item_t)
// out       out_valid / out_stall       out_data  (out_item_t)
// cfg       cfg_valid / cfg_ready       cfg_index, cfg_data
//
// One transaction per cycle in while in_stall is low; out_valid rises once a classify has passed
// select, CRC, multiply and table read and entered the result queue. Write transactions give no result.
// The gate table is one single-port RAM touched at most once per transaction at the same stage.
// Reset clears control state and the config registers only; table entries are undefined until written.
// in_stall rises while 8 classify transactions are outstanding; out_stall holds the queue.

module flow_hash_load_balancer_top
    import fhlb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int ENTRY_W    = GATE_W + 1;

    logic [1:0]         lb_mode_reg;
    logic [COUNT_W-1:0] gate_count_reg;
    logic [COUNT_W-1:0] count_next;

    logic               accept;
    hash_stage_t        stage;

    logic [ENTRY_W-1:0] gate_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;

    logic               s4_valid_reg;
    logic [HASH_W-1:0]  s4_hash_reg;
    logic               s4_zero_reg;

    out_item_t          fifo_mem [FIFO_DEPTH];
    out_item_t          push_item;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fifo_cnt_reg;
    logic [CNT_W-1:0]   credit_reg;
    logic               push;
    logic               pop;
    logic               credit_take;
    logic               hit_drop;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (credit_reg == CNT_W'(FIFO_DEPTH));

    // Clamp the count to the table depth
    assign count_next = (32'(cfg_data[COUNT_W-1:0]) > TABLE_DEPTH) ?
                        COUNT_W'(TABLE_DEPTH) : cfg_data[COUNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lb_mode_reg    <= MODE_L4;
            gate_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LB_MODE:
                begin
                    if (cfg_data[1:0] != MODE_BAD)
                    begin
                        lb_mode_reg <= cfg_data[1:0];
                    end
                end
                REG_GATE_COUNT: gate_count_reg <= count_next;
                default: ;
            endcase
        end
    end

    fhlb_hash u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (in_data),
        .lb_mode    (lb_mode_reg),
        .gate_count (gate_count_reg),
        .stage      (stage)
    );

    // Reads and writes share one stage, so table order follows transaction order
    assign mem_re    = stage.valid && (stage.func == FUNC_CLASSIFY);
    assign mem_we    = stage.valid && (stage.func == FUNC_WRITE)
                       && (32'(stage.entry_index) < TABLE_DEPTH)
                       && (stage.entry_drop || (32'(stage.entry_gate) < GATE_LIMIT));
    assign mem_addr  = mem_we ? IDX_W'(stage.entry_index) : stage.bucket;
    assign mem_wdata = {stage.entry_drop, stage.entry_drop ? GATE_W'(0) : stage.entry_gate};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            gate_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= gate_mem[mem_addr];
        end
        s4_hash_reg <= stage.hash;
        s4_zero_reg <= stage.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= mem_re;
        end
    end

    assign hit_drop            = s4_zero_reg || rd_data_reg[GATE_W];
    assign push_item.out_drop  = hit_drop;
    assign push_item.out_gate  = hit_drop ? GATE_W'(0) : rd_data_reg[GATE_W-1:0];
    assign push_item.flow_hash = s4_hash_reg;

    assign push        = s4_valid_reg;
    assign out_valid   = (fifo_cnt_reg != '0);
    assign out_data    = fifo_mem[rd_ptr_reg];
    assign pop         = out_valid && !out_stall;
    assign credit_take = accept && (in_data.func == FUNC_CLASSIFY);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + CNT_W'(push) - CNT_W'(pop);
            credit_reg   <= credit_reg + CNT_W'(credit_take) - CNT_W'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CNT_W'(FIFO_DEPTH))
        else $error("outstanding classify count exceeds queue depth");

    a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= credit_reg)
        else $error("result queue holds more than outstanding transactions");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_cnt_reg < CNT_W'(FIFO_DEPTH)) || pop)
        else $error("result queue overflow");

    a_drop_gate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_item.out_drop |-> push_item.out_gate == '0)
        else $error("dropped result carries a gate");

    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("gate table read and write in one cycle");
`endif

endmodule

>>> design/fhlb_hash.sv
`timescale 1ns / 1ps

module fhlb_hash
    import fhlb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  in_item_t            item,
    input  logic [1:0]          lb_mode,
    input  logic [COUNT_W-1:0]  gate_count,
    output hash_stage_t         stage
);

    localparam int PROD_W = HASH_W + COUNT_W;

    logic               s1_valid_reg;
    logic               s1_func_reg;
    logic [VEC_W-1:0]   s1_vec_reg;
    logic [INDEX_W-1:0] s1_index_reg;
    logic [GATE_W-1:0]  s1_gate_reg;
    logic               s1_drop_reg;

    logic               s2_valid_reg;
    logic               s2_func_reg;
    logic [HASH_W-1:0]  s2_hash_reg;
    logic [INDEX_W-1:0] s2_index_reg;
    logic [GATE_W-1:0]  s2_gate_reg;
    logic               s2_drop_reg;

    logic               s3_valid_reg;
    logic               s3_func_reg;
    logic [HASH_W-1:0]  s3_hash_reg;
    logic [IDX_W-1:0]   s3_bucket_reg;
    logic               s3_zero_reg;
    logic [INDEX_W-1:0] s3_index_reg;
    logic [GATE_W-1:0]  s3_gate_reg;
    logic               s3_drop_reg;

    logic [VEC_W-1:0]   vec_next;
    logic [HASH_W-1:0]  hash_next;
    logic [PROD_W-1:0]  prod_next;

    // Pick data word and seed by mode
    always_comb
    begin
        case (lb_mode)
            MODE_MAC: vec_next = {item.mac_tail, item.mac_word};
            MODE_IP:  vec_next = {32'd0, item.ip_pair};
            default:  vec_next = {item.port_word ^ {24'd0, item.proto_byte}, item.ip_pair};
        endcase
    end

    always_comb
    begin
        hash_next = '0;
        for (int k = 0; k < VEC_W; k++)
        begin
            if (s1_vec_reg[k])
            begin
                hash_next = hash_next ^ CRC_COLS[k];
            end
        end
    end

    assign prod_next = PROD_W'(s2_hash_reg) * PROD_W'(gate_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_func_reg   <= item.func;
        s1_vec_reg    <= vec_next;
        s1_index_reg  <= item.entry_index;
        s1_gate_reg   <= item.entry_gate;
        s1_drop_reg   <= item.entry_drop;

        s2_func_reg   <= s1_func_reg;
        s2_hash_reg   <= hash_next;
        s2_index_reg  <= s1_index_reg;
        s2_gate_reg   <= s1_gate_reg;
        s2_drop_reg   <= s1_drop_reg;

        s3_func_reg   <= s2_func_reg;
        s3_hash_reg   <= s2_hash_reg;
        s3_bucket_reg <= prod_next[HASH_W +: IDX_W];
        s3_zero_reg   <= (gate_count == '0);
        s3_index_reg  <= s2_index_reg;
        s3_gate_reg   <= s2_gate_reg;
        s3_drop_reg   <= s2_drop_reg;
    end

    assign stage.valid       = s3_valid_reg;
    assign stage.func        = s3_func_reg;
    assign stage.hash        = s3_hash_reg;
    assign stage.bucket      = s3_bucket_reg;
    assign stage.zero        = s3_zero_reg;
    assign stage.entry_index = s3_index_reg;
    assign stage.entry_gate  = s3_gate_reg;
    assign stage.entry_drop  = s3_drop_reg;

endmodule

>>> dv/tb_flow_hash_load_balancer_top.sv
`timescale 1ns / 1ps

module tb_flow_hash_load_balancer_top;
    import fhlb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;
    localparam logic [63:0] ONES64 = '1;
    localparam logic [31:0] ONES32 = '1;
    localparam int PHASE_ITEMS = 130;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 10;

    typedef enum logic { ROW_TXN, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        in_item_t              txn;
        bit                    pinned;
        out_item_t             want;
    } plan_row_t;

    typedef struct packed {
        logic      on;
        out_item_t val;
    } pin_t;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] count;
        bit          quiet;
        bit          press;
    } phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the block's registers and gate table
    logic [1:0]         cur_mode = MODE_L4;
    logic [COUNT_W-1:0] cur_count = '0;
    logic [GATE_W-1:0]  gate_mem [TABLE_DEPTH];
    logic               drop_mem [TABLE_DEPTH];
    bit                 written_map [TABLE_DEPTH];

    out_item_t pending_decisions[$];
    pin_t      pinned_q[$];
    int        errors = 0;
    bit        quiet = 1'b0;
    bit        hold_req = 1'b0;

    flow_hash_load_balancer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [31:0] crc32c_update(logic [63:0] data, logic [31:0] seed);
        logic [31:0] crc;
        crc = seed;
        for (int i = 0; i < 8; i++)
        begin
            crc = crc ^ {24'd0, data[8*i +: 8]};
            for (int b = 0; b < 8; b++)
            begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    function automatic logic [31:0] flow_hash_of(in_item_t it, logic [1:0] mode);
        case (mode)
            MODE_MAC: return crc32c_update(it.mac_word, it.mac_tail);
            MODE_IP:  return crc32c_update(it.ip_pair, 32'd0);
            default:  return crc32c_update(it.ip_pair, it.port_word ^ {24'd0, it.proto_byte});
        endcase
    endfunction

    function automatic int unsigned active_count();
        return (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_count;
    endfunction

    function automatic int unsigned bucket_of(logic [31:0] hash, int unsigned count);
        logic [63:0] prod;
        prod = 64'(hash) * 64'(count);
        return prod[63:32];
    endfunction

    function automatic out_item_t classify_packet(in_item_t it);
        out_item_t   r;
        int unsigned n;
        int unsigned b;
        n = active_count();
        r.flow_hash = flow_hash_of(it, cur_mode);
        r.out_gate = '0;
        r.out_drop = 1'b1;
        if (n != 0)
        begin
            b = bucket_of(r.flow_hash, n);
            r.out_drop = drop_mem[b];
            r.out_gate = drop_mem[b] ? '0 : gate_mem[b];
        end
        return r;
    endfunction

    function automatic in_item_t header_item(logic [63:0] mac, logic [31:0] tail,
                                             logic [63:0] ip, logic [31:0] port,
                                             logic [7:0] proto);
        in_item_t it;
        it = '0;
        it.func = FUNC_CLASSIFY;
        it.mac_word = mac;
        it.mac_tail = tail;
        it.ip_pair = ip;
        it.port_word = port;
        it.proto_byte = proto;
        return it;
    endfunction

    function automatic in_item_t entry_item(int idx, int gate, logic drop);
        in_item_t it;
        it = '0;
        it.func = FUNC_WRITE;
        it.entry_index = INDEX_W'(idx);
        it.entry_gate = GATE_W'(gate);
        it.entry_drop = drop;
        return it;
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        r.txn = '0;
        r.pinned = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic plan_row_t txn_row(in_item_t it);
        plan_row_t r;
        r = cfg_row('0, '0);
        r.kind = ROW_TXN;
        r.txn = it;
        return r;
    endfunction

    function automatic plan_row_t pinned_row(in_item_t it, int gate, logic drop,
                                             logic [31:0] hash);
        plan_row_t r;
        r = txn_row(it);
        r.pinned = 1'b1;
        r.want.out_gate = GATE_W'(gate);
        r.want.out_drop = drop;
        r.want.flow_hash = hash;
        return r;
    endfunction

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic int random_gate();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? GATE_LIMIT - 1 : 0;
        return $urandom_range(0, GATE_LIMIT - 1);
    endfunction

    // Update the shadow table for each accepted write and queue the expected decision for each accepted classify
    task automatic accept_txn(in_item_t it);
        pin_t pin;
        pin = pinned_q.pop_front();
        if (it.func == FUNC_WRITE)
        begin
            if (it.entry_index < TABLE_DEPTH && (it.entry_drop || it.entry_gate < GATE_LIMIT))
            begin
                gate_mem[it.entry_index] = it.entry_drop ? '0 : it.entry_gate;
                drop_mem[it.entry_index] = it.entry_drop;
            end
        end
        else if (pin.on)
            pending_decisions.push_back(pin.val);
        else
            pending_decisions.push_back(classify_packet(it));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            accept_txn(in_data);
    end

    // Result side: check each decision, then draw the stall before the next one
    initial
    begin
        out_item_t exp;
        int        wait_left;
        int        hold_left;
        wait_left = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_decisions.size() == 0)
                begin
                    $error("result with nothing pending: gate %0d drop %0d hash %h",
                           out_data.out_gate, out_data.out_drop, out_data.flow_hash);
                    errors++;
                end
                else
                begin
                    exp = pending_decisions.pop_front();
                    if (out_data.out_gate !== exp.out_gate)
                    begin
                        $error("out_gate: expected %0d, actual %0d",
                               exp.out_gate, out_data.out_gate);
                        errors++;
                    end
                    if (out_data.out_drop !== exp.out_drop)
                    begin
                        $error("out_drop: expected %0d, actual %0d",
                               exp.out_drop, out_data.out_drop);
                        errors++;
                    end
                    if (out_data.flow_hash !== exp.flow_hash)
                    begin
                        $error("flow_hash: expected %h, actual %h",
                               exp.flow_hash, out_data.flow_hash);
                        errors++;
                    end
                end
                wait_left = draw_wait();
            end
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_txn(in_item_t it, bit pinned, out_item_t want);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pinned_q.push_back('{pinned, want});
        if (it.func == FUNC_WRITE)
            written_map[it.entry_index] = 1'b1;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Never let a classify land on a table entry that was never written
    task automatic send_header(in_item_t it, bit pinned, out_item_t want);
        int unsigned n;
        int unsigned b;
        n = active_count();
        if (n != 0)
        begin
            b = bucket_of(flow_hash_of(it, cur_mode), n);
            if (!written_map[b])
                send_txn(entry_item(b, random_gate(), $urandom_range(0, 3) == 0), 1'b0, '0);
        end
        send_txn(it, pinned, want);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_decisions.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_LB_MODE && val[1:0] != MODE_BAD)
            cur_mode = val[1:0];
        else if (idx == REG_GATE_COUNT)
            cur_count = val[COUNT_W-1:0];
        @(posedge clk);
    endtask

    initial
    begin
        plan_row_t plan[$];
        phase_t    phases[$];
        in_item_t  it;
        int        n;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Zero header fields hash to zero, so those rows always land on entry 0
        plan = '{
            pinned_row(header_item(0, 0, 0, 0, 0), 0, 1'b1, 0),
            txn_row(header_item(ONES64, ONES32, ONES64, ONES32, 8'hFF)),
            txn_row(entry_item(0, GATE_LIMIT - 1, 1'b0)),
            txn_row(entry_item(TABLE_DEPTH - 1, 0, 1'b1)),
            cfg_row(REG_GATE_COUNT, 16'd1),
            pinned_row(header_item(0, 0, 0, 0, 0), GATE_LIMIT - 1, 1'b0, 0),
            txn_row(entry_item(0, GATE_LIMIT - 1, 1'b1)),
            pinned_row(header_item(0, 0, 0, 0, 0), 0, 1'b1, 0),
            cfg_row(REG_LB_MODE, 16'(MODE_IP)),
            pinned_row(header_item(ONES64, ONES32, 0, ONES32, 8'hFF), 0, 1'b1, 0),
            cfg_row(REG_LB_MODE, 16'hFFFF),
            pinned_row(header_item(ONES64, ONES32, 0, ONES32, 8'hFF), 0, 1'b1, 0),
            cfg_row(REG_UNUSED, 16'hFFFF),
            txn_row(entry_item(0, 'h1555, 1'b0)),
            pinned_row(header_item(0, 0, 0, 0, 0), 'h1555, 1'b0, 0),
            txn_row(header_item(ONES64, ONES32, ONES64, ONES32, 8'hFF)),
            cfg_row(REG_GATE_COUNT, 16'hFFFF),
            cfg_row(REG_LB_MODE, 16'hFFFC),
            pinned_row(header_item(0, 0, ONES64, ONES32, 8'hFF), 'h1555, 1'b0, 0),
            txn_row(header_item(ONES64, ONES32, 0, 0, 0)),
            txn_row(header_item(64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF, 0, 0, 0)),
            cfg_row(REG_LB_MODE, 16'(MODE_L4)),
            txn_row(header_item(0, 0, ONES64, 0, 8'hFF)),
            txn_row(header_item(0, 0, 64'hFEDC_BA98_7654_3210, ONES32, 8'h00)),
            txn_row(header_item(0, 0, 0, 32'h8000_0000, 8'h80)),
            txn_row(entry_item(TABLE_DEPTH - 1, GATE_LIMIT - 1, 1'b0))
        };

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else if (plan[i].txn.func == FUNC_CLASSIFY)
                send_header(plan[i].txn, plan[i].pinned, plan[i].want);
            else
                send_txn(plan[i].txn, 1'b0, '0);
        end

        phases = '{
            '{MODE_L4,  16'd2,     1'b0, 1'b0},
            '{MODE_MAC, 16'd16384, 1'b1, 1'b1},
            '{MODE_IP,  16'd3,     1'b0, 1'b0},
            '{MODE_L4,  16'h7FFF,  1'b0, 1'b0},
            '{MODE_MAC, 16'd0,     1'b0, 1'b0},
            '{MODE_IP,  16'd1000,  1'b0, 1'b0}
        };

        foreach (phases[p])
        begin
            settle();
            write_reg(REG_LB_MODE, {14'($urandom), phases[p].mode});
            write_reg(REG_GATE_COUNT, {1'($urandom), phases[p].count[COUNT_W-1:0]});
            quiet = phases[p].quiet;
            if (phases[p].press)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                n = active_count();
                if ($urandom_range(0, 9) < 3)
                begin
                    // Aim half of the writes at the part of the table in use
                    it = entry_item((n != 0 && $urandom_range(0, 1)) ?
                                    $urandom_range(0, n - 1) : $urandom_range(0, TABLE_DEPTH - 1),
                                    random_gate(), $urandom_range(0, 3) == 0);
                    send_txn(it, 1'b0, '0);
                end
                else
                begin
                    it = header_item({$urandom, $urandom}, $urandom, {$urandom, $urandom},
                                     $urandom, 8'($urandom));
                    send_header(it, 1'b0, '0);
                end
            end
            quiet = 1'b0;
        end

        settle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
